// ===== sv/csa_pkg.sv =====
// Shared constants, register codes and elaboration-time helpers for the capsule aperture block.
package csa_pkg;

    localparam int COORD_BITS        = 21;
    localparam int SIGMOID_FRAC_BITS = 16;

    localparam int CFG_DATA_BITS = 63;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_WORD_BITS = 32;
    localparam int APT_BITS      = 32;

    localparam int EXP_FRAC_BITS = 16;
    localparam int ACC_BITS      = 31;
    localparam int ACC_SHIFT     = 30;

    localparam logic signed [31:0] LOG2E_Q30   = 32'sd1549082005;
    localparam logic signed [31:0] SLOPE_RESET = 32'sd65536;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SEG_START = 3'd0,
        REG_SEG_END   = 3'd1,
        REG_APT_HIGH  = 3'd2,
        REG_APT_LOW   = 3'd3,
        REG_SIG_MID   = 3'd4,
        REG_SIG_SLOPE = 3'd5
    } t_reg_idx;

    // Q30 factor 2^(2^-(16-b)) chain: repeated floor square roots starting from 2.0
    function automatic logic [ACC_BITS-1:0] f_exp_root(input int b);
        logic [63:0] root;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bitv;
        root = 64'd1 << 31;
        for (int k = EXP_FRAC_BITS - 1; k >= b; k--) begin
            v    = root << ACC_SHIFT;
            r    = 64'd0;
            bitv = 64'd1 << 62;
            for (int j = 0; j < 32; j++) begin
                if (v >= r + bitv) begin
                    v = v - (r + bitv);
                    r = (r >> 1) + bitv;
                end else begin
                    r = r >> 1;
                end
                bitv = bitv >> 2;
            end
            root = r;
        end
        return root[ACC_BITS-1:0];
    endfunction

endpackage

// ===== sv/csa_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a sideband that rides along.
module csa_div_pipe #(
    parameter int NUM_BITS  = 88,
    parameter int DEN_BITS  = 44,
    parameter int QUO_BITS  = 44,
    parameter int SIDE_BITS = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [NUM_BITS-1:0]  i_num,
    input  logic [DEN_BITS-1:0]  i_den,
    input  logic [SIDE_BITS-1:0] i_side,
    output logic                 o_valid,
    output logic [QUO_BITS-1:0]  o_quot,
    output logic [SIDE_BITS-1:0] o_side
);

    localparam int REM_BITS = DEN_BITS + 1;

    logic                 r_valid [0:QUO_BITS-1];
    logic [REM_BITS-1:0]  r_rem   [0:QUO_BITS-1];
    logic [QUO_BITS-1:0]  r_quot  [0:QUO_BITS-1];
    logic [NUM_BITS-1:0]  r_num   [0:QUO_BITS-1];
    logic [DEN_BITS-1:0]  r_den   [0:QUO_BITS-1];
    logic [SIDE_BITS-1:0] r_side  [0:QUO_BITS-1];

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
        logic                 v_in;
        logic [REM_BITS-1:0]  rem_in;
        logic [QUO_BITS-1:0]  quot_in;
        logic [NUM_BITS-1:0]  num_in;
        logic [DEN_BITS-1:0]  den_in;
        logic [SIDE_BITS-1:0] side_in;
        logic [REM_BITS-1:0]  trial;
        logic                 take;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = REM_BITS'(i_num >> QUO_BITS);
            assign quot_in = '0;
            assign num_in  = i_num;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_valid[k-1];
            assign rem_in  = r_rem[k-1];
            assign quot_in = r_quot[k-1];
            assign num_in  = r_num[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
        end

        assign trial = {rem_in[REM_BITS-2:0], num_in[QUO_BITS-1-k]};
        assign take  = (trial >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= take ? (trial - {1'b0, den_in}) : trial;
            r_quot[k] <= {quot_in[QUO_BITS-2:0], take};
            r_num[k]  <= num_in;
            r_den[k]  <= den_in;
            r_side[k] <= side_in;
        end
    end

    assign o_valid = r_valid[QUO_BITS-1];
    assign o_quot  = r_quot[QUO_BITS-1];
    assign o_side  = r_side[QUO_BITS-1];

endmodule

// ===== sv/csa_isqrt_pipe.sv =====
// Pipelined floor square root, one root bit per stage.
module csa_isqrt_pipe #(
    parameter int VAL_BITS = 44
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [VAL_BITS-1:0]   i_val,
    output logic                  o_valid,
    output logic [VAL_BITS/2-1:0] o_root
);

    localparam int ROOT_BITS = VAL_BITS / 2;
    localparam int REM_BITS  = ROOT_BITS + 2;

    logic                 r_valid [0:ROOT_BITS-1];
    logic [REM_BITS-1:0]  r_rem   [0:ROOT_BITS-1];
    logic [ROOT_BITS-1:0] r_root  [0:ROOT_BITS-1];
    logic [VAL_BITS-1:0]  r_val   [0:ROOT_BITS-1];

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
        logic                 v_in;
        logic [REM_BITS-1:0]  rem_in;
        logic [ROOT_BITS-1:0] root_in;
        logic [VAL_BITS-1:0]  val_in;
        logic [REM_BITS-1:0]  rem_sh;
        logic [REM_BITS-1:0]  trial;
        logic                 take;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = i_val;
        end else begin : g_next
            assign v_in    = r_valid[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign val_in  = r_val[k-1];
        end

        assign rem_sh = {rem_in[REM_BITS-3:0], val_in[VAL_BITS-1-2*k -: 2]};
        assign trial  = {root_in, 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= take ? (rem_sh - trial) : rem_sh;
            r_root[k] <= {root_in[ROOT_BITS-2:0], take};
            r_val[k]  <= val_in;
        end
    end

    assign o_valid = r_valid[ROOT_BITS-1];
    assign o_root  = r_root[ROOT_BITS-1];

endmodule

// ===== sv/capsule_sigmoid_aperture.sv =====
// Top level: point-to-segment distance, logistic weight and aperture blend, fully pipelined.
//
//   channel   direction  handshake                 payload
//   point     in         start & !busy             i_point_x, i_point_y, i_point_z
//   aperture  out        o_valid (one cycle)       o_aperture
//   config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One point per clock; busy never rises.
// The path runs through the two one-bit-per-stage dividers, the square root pipeline and
// the sixteen-stage exponent multiply chain.
// Synchronous reset clears the valid bits and restores the configuration registers to their defaults.
// The pipeline never stalls; a result is presented for exactly one cycle.
module capsule_sigmoid_aperture #(
    parameter int COORD_BITS        = csa_pkg::COORD_BITS,
    parameter int SIGMOID_FRAC_BITS = csa_pkg::SIGMOID_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [COORD_BITS-1:0]         i_point_x,
    input  logic signed [COORD_BITS-1:0]         i_point_y,
    input  logic signed [COORD_BITS-1:0]         i_point_z,
    output logic                                 o_valid,
    output logic [csa_pkg::APT_BITS-1:0]         o_aperture,
    input  logic                                 i_cfg_we,
    input  logic [csa_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [csa_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    localparam int CB   = COORD_BITS;
    localparam int F    = SIGMOID_FRAC_BITS;
    localparam int WB   = csa_pkg::CFG_WORD_BITS;
    localparam int AB   = csa_pkg::APT_BITS;
    localparam int DIF  = CB + 1;
    localparam int PRD  = 2 * DIF;
    localparam int DOT  = PRD + 1;
    localparam int CRS  = PRD + 1;
    localparam int CMAG = 2 * CB + 1;
    localparam int HB   = CB + 1;
    localparam int NSQ  = 2 * CB + 2;
    localparam int SQW  = 4 * CB + 2;
    localparam int NUMW = 4 * CB + 4;
    localparam int RTW  = CB + 1;
    localparam int DZW  = WB + 2;
    localparam int ZPW  = WB + DZW;
    localparam int ZW   = WB + 1;
    localparam int YPW  = ZW + WB;
    localparam int YSH  = 40;
    localparam int YW   = 23;
    localparam int UW   = YW - 1;
    localparam int EFB  = csa_pkg::EXP_FRAC_BITS;
    localparam int IPW  = UW - EFB;
    localparam int ACW  = csa_pkg::ACC_BITS;
    localparam int ASH  = csa_pkg::ACC_SHIFT;
    localparam int SNW  = F + 32;
    localparam int SDW  = F + 33;
    localparam int SQB  = F + 1;
    localparam int OSW  = AB + F + 2;

    localparam logic signed [ZPW-1:0] ZLIM = ZPW'(64'd1 << 31);
    localparam logic signed [YPW-1:0] YRND = YPW'((64'd1 << YSH) - 64'd1);
    localparam logic [SQB-1:0]        SONE = SQB'(1) << F;
    localparam logic [SDW-1:0]        DEN_ONE = SDW'(1) << ASH;
    localparam logic [SNW-1:0]        NUM_ONE = SNW'(1) << (F + ASH);
    localparam logic [OSW-1:0]        HALF_LSB = OSW'(1) << (F - 1);

    // configuration registers
    logic [3*CB-1:0]       r_cfg_start;
    logic [3*CB-1:0]       r_cfg_end;
    logic [AB-1:0]         r_cfg_ahi;
    logic [AB-1:0]         r_cfg_alo;
    logic signed [WB-1:0]  r_cfg_mid;
    logic signed [WB-1:0]  r_cfg_slope;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_start <= '0;
            r_cfg_end   <= '0;
            r_cfg_ahi   <= '0;
            r_cfg_alo   <= '0;
            r_cfg_mid   <= '0;
            r_cfg_slope <= csa_pkg::SLOPE_RESET;
        end else if (i_cfg_we) begin
            unique case (csa_pkg::t_reg_idx'(i_cfg_idx))
                csa_pkg::REG_SEG_START: r_cfg_start <= i_cfg_data[3*CB-1:0];
                csa_pkg::REG_SEG_END:   r_cfg_end   <= i_cfg_data[3*CB-1:0];
                csa_pkg::REG_APT_HIGH:  r_cfg_ahi   <= i_cfg_data[AB-1:0];
                csa_pkg::REG_APT_LOW:   r_cfg_alo   <= i_cfg_data[AB-1:0];
                csa_pkg::REG_SIG_MID:   r_cfg_mid   <= i_cfg_data[WB-1:0];
                csa_pkg::REG_SIG_SLOPE: r_cfg_slope <= i_cfg_data[WB-1:0];
                default: ;
            endcase
        end
    end

    // segment terms derived from configuration
    logic signed [CB-1:0]  pa_a [3];
    logic signed [CB-1:0]  pa_b [3];
    logic signed [CB-1:0]  pt   [3];
    logic signed [DIF-1:0] r_seg   [3];
    logic signed [PRD-1:0] r_segsq [3];
    logic [NSQ-1:0]        r_len2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pa_a[i] = r_cfg_start[CB*i +: CB];
            pa_b[i] = r_cfg_end[CB*i +: CB];
        end
    end

    assign pt[0] = i_point_x;
    assign pt[1] = i_point_y;
    assign pt[2] = i_point_z;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_seg[i]   <= DIF'(pa_b[i]) - DIF'(pa_a[i]);
            r_segsq[i] <= r_seg[i] * r_seg[i];
        end
        r_len2 <= r_segsq[0] + r_segsq[1] + r_segsq[2];
    end

    assign busy = 1'b0;

    // front end: differences, products, sums, case select, cross-product squares
    logic                  r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;
    logic signed [DIF-1:0] r1_pa [3];
    logic signed [DIF-1:0] r1_pb [3];
    logic signed [PRD-1:0] r2_da [3];
    logic signed [PRD-1:0] r2_db [3];
    logic signed [PRD-1:0] r2_x  [6];
    logic signed [PRD-1:0] r2_qa [3];
    logic signed [PRD-1:0] r2_qb [3];
    logic signed [DOT-1:0] r3_dota, r3_dotb;
    logic signed [CRS-1:0] r3_c [3];
    logic [NSQ-1:0]        r3_nsa, r3_nsb;
    logic                  r4_mid, r5_mid, r6_mid;
    logic [NSQ-1:0]        r4_endsum, r5_endsum, r6_endsum;
    logic [CMAG-1:0]       cmag [3];
    logic [2*CB-1:0]       r4_hh [3];
    logic [CB+HB-1:0]      r4_hl [3];
    logic [2*HB-1:0]       r4_ll [3];
    logic [SQW-1:0]        r5_sq [3];
    logic [NUMW-1:0]       r6_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else begin
            r1_v <= start && !busy;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cmag[i] = CMAG'(r3_c[i][CRS-1] ? -r3_c[i] : r3_c[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_pa[i] <= DIF'(pt[i]) - DIF'(pa_a[i]);
            r1_pb[i] <= DIF'(pt[i]) - DIF'(pa_b[i]);
            r2_da[i] <= r1_pa[i] * r_seg[i];
            r2_db[i] <= r1_pb[i] * r_seg[i];
            r2_qa[i] <= r1_pa[i] * r1_pa[i];
            r2_qb[i] <= r1_pb[i] * r1_pb[i];
            r4_hh[i] <= cmag[i][CMAG-1:HB] * cmag[i][CMAG-1:HB];
            r4_hl[i] <= cmag[i][CMAG-1:HB] * cmag[i][HB-1:0];
            r4_ll[i] <= cmag[i][HB-1:0] * cmag[i][HB-1:0];
            r5_sq[i] <= {r4_hh[i], (2*HB)'(0)} + (SQW'(r4_hl[i]) << (HB + 1))
                        + SQW'(r4_ll[i]);
        end
        r2_x[0] <= r1_pa[1] * r1_pb[2];
        r2_x[1] <= r1_pa[2] * r1_pb[1];
        r2_x[2] <= r1_pa[2] * r1_pb[0];
        r2_x[3] <= r1_pa[0] * r1_pb[2];
        r2_x[4] <= r1_pa[0] * r1_pb[1];
        r2_x[5] <= r1_pa[1] * r1_pb[0];

        r3_dota <= DOT'(r2_da[0]) + DOT'(r2_da[1]) + DOT'(r2_da[2]);
        r3_dotb <= DOT'(r2_db[0]) + DOT'(r2_db[1]) + DOT'(r2_db[2]);
        r3_c[0] <= CRS'(r2_x[0]) - CRS'(r2_x[1]);
        r3_c[1] <= CRS'(r2_x[2]) - CRS'(r2_x[3]);
        r3_c[2] <= CRS'(r2_x[4]) - CRS'(r2_x[5]);
        r3_nsa  <= r2_qa[0] + r2_qa[1] + r2_qa[2];
        r3_nsb  <= r2_qb[0] + r2_qb[1] + r2_qb[2];

        r4_mid    <= (r3_dota > 0) && (r3_dotb < 0);
        r4_endsum <= (r3_dota <= 0) ? r3_nsa : r3_nsb;
        r5_mid    <= r4_mid;
        r5_endsum <= r4_endsum;
        r6_mid    <= r5_mid;
        r6_endsum <= r5_endsum;
        r6_num    <= NUMW'(r5_sq[0]) + NUMW'(r5_sq[1]) + NUMW'(r5_sq[2]);
    end

    // perpendicular distance squared
    logic           d1_v;
    logic [NSQ-1:0] d1_quot;
    logic [NSQ:0]   d1_side;

    csa_div_pipe #(
        .NUM_BITS  (NUMW),
        .DEN_BITS  (NSQ),
        .QUO_BITS  (NSQ),
        .SIDE_BITS (NSQ + 1)
    ) u_dist_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r6_v),
        .i_num   (r6_num),
        .i_den   (r_len2),
        .i_side  ({r6_mid, r6_endsum}),
        .o_valid (d1_v),
        .o_quot  (d1_quot),
        .o_side  (d1_side)
    );

    logic           r7_v;
    logic [NSQ-1:0] r7_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else begin
            r7_v <= d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_val <= d1_side[NSQ] ? d1_quot : d1_side[NSQ-1:0];
    end

    logic           sq_v;
    logic [RTW-1:0] sq_root;

    csa_isqrt_pipe #(
        .VAL_BITS (NSQ)
    ) u_dist_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r7_v),
        .i_val   (r7_val),
        .o_valid (sq_v),
        .o_root  (sq_root)
    );

    // exponent argument
    logic                  r8_v, r9_v, r10_v, r11_v;
    logic signed [DZW-1:0] dist_ext;
    logic signed [DZW-1:0] r8_diff;
    logic signed [ZPW-1:0] r9_z;
    logic signed [ZW-1:0]  zc;
    logic signed [YPW-1:0] r10_yp;
    logic signed [YPW-1:0] yadj;
    logic signed [YW-1:0]  y;
    logic [UW-1:0]         u;
    logic                  r11_neg;
    logic [IPW-1:0]        r11_ip;
    logic [EFB-1:0]        r11_fr;

    assign dist_ext = DZW'(sq_root);

    always_comb begin
        if (r9_z > ZLIM) begin
            zc = ZW'(ZLIM);
        end else if (r9_z < -ZLIM) begin
            zc = -ZW'(ZLIM);
        end else begin
            zc = ZW'(r9_z);
        end
    end

    assign yadj = r10_yp + (r10_yp[YPW-1] ? YRND : YPW'(0));
    assign y    = yadj[YSH +: YW];
    assign u    = UW'(y[YW-1] ? -y : y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            r11_v <= 1'b0;
        end else begin
            r8_v  <= sq_v;
            r9_v  <= r8_v;
            r10_v <= r9_v;
            r11_v <= r10_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r8_diff <= dist_ext - DZW'(r_cfg_mid);
        r9_z    <= r_cfg_slope * r8_diff;
        r10_yp  <= zc * csa_pkg::LOG2E_Q30;
        r11_neg <= y[YW-1];
        r11_ip  <= u[UW-1:EFB];
        r11_fr  <= u[EFB-1:0];
    end

    // 2^frac as a chain of Q30 multiplies, highest fraction bit first
    logic           r_e_v   [0:EFB-1];
    logic [ACW-1:0] r_e_acc [0:EFB-1];
    logic [IPW-1:0] r_e_ip  [0:EFB-1];
    logic [EFB-1:0] r_e_fr  [0:EFB-1];
    logic           r_e_neg [0:EFB-1];

    for (genvar j = 0; j < EFB; j++) begin : g_exp
        localparam logic [ACW-1:0] ROOT = csa_pkg::f_exp_root(EFB - 1 - j);
        logic               v_in;
        logic [ACW-1:0]     acc_in;
        logic [IPW-1:0]     ip_in;
        logic [EFB-1:0]     fr_in;
        logic               neg_in;
        logic [2*ACW-1:0]   prod;

        if (j == 0) begin : g_first
            assign v_in   = r11_v;
            assign acc_in = ACW'(1) << ASH;
            assign ip_in  = r11_ip;
            assign fr_in  = r11_fr;
            assign neg_in = r11_neg;
        end else begin : g_next
            assign v_in   = r_e_v[j-1];
            assign acc_in = r_e_acc[j-1];
            assign ip_in  = r_e_ip[j-1];
            assign fr_in  = r_e_fr[j-1];
            assign neg_in = r_e_neg[j-1];
        end

        assign prod = acc_in * ROOT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_e_v[j] <= 1'b0;
            end else begin
                r_e_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_e_acc[j] <= fr_in[EFB-1-j] ? prod[ASH +: ACW] : acc_in;
            r_e_ip[j]  <= ip_in;
            r_e_fr[j]  <= fr_in;
            r_e_neg[j] <= neg_in;
        end
    end

    // logistic weight g = round(2^(F+30) / (2^30 + 2^frac << int))
    logic           sat;
    logic [SDW-1:0] den;
    logic           rd_v;
    logic [SDW-1:0] rd_den;
    logic [SNW-1:0] rd_num;
    logic           rd_neg, rd_sat;

    assign sat = (r_e_ip[EFB-1] >= IPW'(F + 2));
    assign den = DEN_ONE + (SDW'(r_e_acc[EFB-1]) << r_e_ip[EFB-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_v <= 1'b0;
        end else begin
            rd_v <= r_e_v[EFB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        rd_den <= den;
        rd_num <= NUM_ONE + SNW'(den >> 1);
        rd_neg <= r_e_neg[EFB-1];
        rd_sat <= sat;
    end

    logic           d2_v;
    logic [SQB-1:0] d2_quot;
    logic [1:0]     d2_side;

    csa_div_pipe #(
        .NUM_BITS  (SNW),
        .DEN_BITS  (SDW),
        .QUO_BITS  (SQB),
        .SIDE_BITS (2)
    ) u_sig_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rd_v),
        .i_num   (rd_num),
        .i_den   (rd_den),
        .i_side  ({rd_neg, rd_sat}),
        .o_valid (d2_v),
        .o_quot  (d2_quot),
        .o_side  (d2_side)
    );

    // blend and saturate
    logic              r29_v, r30_v;
    logic [SQB-1:0]    g;
    logic [SQB-1:0]    r29_s;
    logic [AB+SQB-1:0] r30_plo, r30_phi;
    logic [OSW-1:0]    osum;
    logic [OSW-F-1:0]  oshift;

    assign g      = d2_side[0] ? '0 : d2_quot;
    assign osum   = OSW'(r30_plo) + OSW'(r30_phi) + HALF_LSB;
    assign oshift = osum[OSW-1:F];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r29_v   <= 1'b0;
            r30_v   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r29_v   <= d2_v;
            r30_v   <= r29_v;
            o_valid <= r30_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r29_s      <= d2_side[1] ? (SONE - g) : g;
        r30_plo    <= r_cfg_alo * (SONE - r29_s);
        r30_phi    <= r_cfg_ahi * r29_s;
        o_aperture <= (|oshift[OSW-F-1:AB]) ? {AB{1'b1}} : oshift[AB-1:0];
    end

`ifndef SYNTHESIS
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    a_perp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d1_v && d1_side[NSQ]) |-> (d1_quot <= d1_side[NSQ-1:0]))
        else $error("perpendicular distance exceeds end point distance");

    a_sqrt_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_v |-> $past(r7_v, RTW))
        else $error("square root valid without matching input");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r29_v |-> (r29_s <= SONE))
        else $error("logistic weight above one");
`endif

endmodule

// ===== tb/csa_checker.sv =====
// Watches the point, config and aperture channels; predicts apertures and compares them.
`timescale 1ns / 1ps
module csa_checker (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  logic signed [20:0]       i_px,
    input  logic signed [20:0]       i_py,
    input  logic signed [20:0]       i_pz,
    input  logic                     i_valid,
    input  logic [31:0]              i_aperture,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_idx,
    input  logic [62:0]              i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending
);

    logic [62:0] seg_a, seg_b;
    logic [31:0] apt_hi, apt_lo, sig_mid, sig_slope;
    logic [31:0] apertures_due[$];

    function automatic bit [63:0] isqrt(input bit [63:0] v);
        bit [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint coord(input logic [62:0] packed_pt, input int k);
        logic [20:0] c;
        c = packed_pt[21*k +: 21];
        return longint'($signed(c));
    endfunction

    function automatic bit [63:0] norm_sq_root(input longint v0, v1, v2);
        return isqrt(64'(v0 * v0) + 64'(v1 * v1) + 64'(v2 * v2));
    endfunction

    // logistic weight in Q16 for z in Q.26
    function automatic bit [63:0] logistic_weight(input longint z);
        longint y;
        bit [63:0] u, ip, fr, acc, root, den, g;
        if (z > (64'sd1 <<< 31)) z = 64'sd1 <<< 31;
        if (z < -(64'sd1 <<< 31)) z = -(64'sd1 <<< 31);
        y = (z * 64'sd1549082005) / (64'sd1 <<< 40);
        u = y < 0 ? 64'(-y) : 64'(y);
        ip = u >> 16;
        fr = u & 64'hFFFF;
        acc = 64'd1 << 30;
        root = 64'd1 << 31;
        g = 0;
        if (ip < csa_pkg::SIGMOID_FRAC_BITS + 2) begin
            for (int b = 15; b >= 0; b--) begin
                root = isqrt(root << 30);
                if (fr[b]) acc = (acc * root) >> 30;
            end
            den = (64'd1 << 30) + (acc << ip);
            g = ((64'd1 << (csa_pkg::SIGMOID_FRAC_BITS + 30)) + den / 2) / den;
        end
        return y >= 0 ? g : (64'd1 << csa_pkg::SIGMOID_FRAC_BITS) - g;
    endfunction

    function automatic bit [31:0] predict_aperture(input longint px, py, pz);
        longint a[3], b[3], p[3], sg[3], pa[3], pb[3], c[3];
        longint dot_a, dot_b, z;
        bit [63:0] distance, s, len2, quo;
        bit [127:0] cross2, sum;
        for (int k = 0; k < 3; k++) begin
            a[k] = coord(seg_a, k);
            b[k] = coord(seg_b, k);
        end
        p[0] = px; p[1] = py; p[2] = pz;
        for (int k = 0; k < 3; k++) begin
            sg[k] = b[k] - a[k];
            pa[k] = p[k] - a[k];
            pb[k] = p[k] - b[k];
        end
        dot_a = sg[0] * pa[0] + sg[1] * pa[1] + sg[2] * pa[2];
        dot_b = sg[0] * pb[0] + sg[1] * pb[1] + sg[2] * pb[2];
        if (dot_a <= 0) begin
            distance = norm_sq_root(pa[0], pa[1], pa[2]);
        end else if (dot_b >= 0) begin
            distance = norm_sq_root(pb[0], pb[1], pb[2]);
        end else begin
            c[0] = pa[1] * pb[2] - pa[2] * pb[1];
            c[1] = pa[2] * pb[0] - pa[0] * pb[2];
            c[2] = pa[0] * pb[1] - pa[1] * pb[0];
            cross2 = 0;
            len2 = 0;
            for (int k = 0; k < 3; k++) begin
                cross2 = cross2 + 128'($signed(c[k])) * 128'($signed(c[k]));
                len2 = len2 + 64'(sg[k] * sg[k]);
            end
            if (len2 != 0) begin
                quo = 64'(cross2 / 128'(len2));
                distance = isqrt(quo);
            end else begin
                distance = norm_sq_root(pa[0], pa[1], pa[2]);
            end
        end
        z = longint'($signed(sig_slope)) * (longint'(distance) - longint'($signed(sig_mid)));
        s = logistic_weight(z);
        sum = 128'(apt_lo) * 128'((64'd1 << csa_pkg::SIGMOID_FRAC_BITS) - s)
              + 128'(apt_hi) * 128'(s);
        sum = (sum + (128'd1 << (csa_pkg::SIGMOID_FRAC_BITS - 1)))
              >> csa_pkg::SIGMOID_FRAC_BITS;
        if (sum > 128'hFFFF_FFFF) sum = 128'hFFFF_FFFF;
        return sum[31:0];
    endfunction

    assign o_pending = apertures_due.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seg_a <= '0;
            seg_b <= '0;
            apt_hi <= '0;
            apt_lo <= '0;
            sig_mid <= '0;
            sig_slope <= csa_pkg::SLOPE_RESET;
            apertures_due.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    csa_pkg::REG_SEG_START: seg_a <= i_cfg_data;
                    csa_pkg::REG_SEG_END:   seg_b <= i_cfg_data;
                    csa_pkg::REG_APT_HIGH:  apt_hi <= i_cfg_data[31:0];
                    csa_pkg::REG_APT_LOW:   apt_lo <= i_cfg_data[31:0];
                    csa_pkg::REG_SIG_MID:   sig_mid <= i_cfg_data[31:0];
                    csa_pkg::REG_SIG_SLOPE: sig_slope <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (i_valid) begin
                if (apertures_due.size() == 0) begin
                    $display("%0t: unexpected aperture transaction, actual %h", $time,
                             i_aperture);
                    o_fail_count <= o_fail_count + 1;
                end else if (apertures_due[0] !== i_aperture) begin
                    $display("%0t: aperture mismatch, expected %h actual %h", $time,
                             apertures_due[0], i_aperture);
                    o_fail_count <= o_fail_count + 1;
                    void'(apertures_due.pop_front());
                end else begin
                    void'(apertures_due.pop_front());
                end
            end
            if (i_start && !i_busy)
                apertures_due.push_back(predict_aperture(i_px, i_py, i_pz));
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: drives points and register writes into the aperture block and reports.
`timescale 1ns / 1ps
module tb_top;

    localparam logic [2:0] REG_UNUSED = 3'd6;
    localparam logic [2:0] REG_UNUSED_TOP = 3'd7;
    localparam int DRAIN_CYCLES = 140;
    localparam int NEAR = 8192;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    logic signed [20:0] i_point_x = 0, i_point_y = 0, i_point_z = 0;
    logic o_valid;
    logic [31:0] o_aperture;
    logic i_cfg_we = 0;
    logic [2:0] i_cfg_idx = 0;
    logic [62:0] i_cfg_data = 0;
    int fail_count, pending;
    int n_sent = 0;
    int idle_pct = 0;

    always #5 i_clk = ~i_clk;

    capsule_sigmoid_aperture dut (.*);

    csa_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_px(i_point_x), .i_py(i_point_y), .i_pz(i_point_z),
        .i_valid(o_valid), .i_aperture(o_aperture),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic logic [62:0] pack_pt(input int x, y, z);
        return {21'(z), 21'(y), 21'(x)};
    endfunction

    function automatic int rand_coord(input int spread);
        int r;
        r = $urandom_range(99);
        if (r < 8) return $signed(21'($urandom));
        if (r < 11) return r[0] ? -1048576 : 1048575;
        return int'($urandom_range(2 * spread)) - spread;
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [62:0] data);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic cfg_done();
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic send_point(input int x, y, z);
        if ($urandom_range(99) < idle_pct) begin
            start <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start <= 1;
        i_point_x <= 21'(x);
        i_point_y <= 21'(y);
        i_point_z <= 21'(z);
        while (busy) @(posedge i_clk);
        @(posedge i_clk);
        n_sent++;
    endtask

    task automatic drain();
        start <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_config(input int k);
        int ax, ay, az;
        ax = $urandom_range(2 * NEAR) - NEAR;
        ay = $urandom_range(2 * NEAR) - NEAR;
        az = $urandom_range(2 * NEAR) - NEAR;
        cfg_write(csa_pkg::REG_SEG_START, pack_pt(ax, ay, az));
        if (k % 5 == 3)
            cfg_write(csa_pkg::REG_SEG_END, pack_pt(ax, ay, az));
        else
            cfg_write(csa_pkg::REG_SEG_END, pack_pt($urandom_range(2 * NEAR) - NEAR,
                      $urandom_range(2 * NEAR) - NEAR, $urandom_range(2 * NEAR) - NEAR));
        cfg_write(csa_pkg::REG_APT_HIGH, {31'($urandom), 32'($urandom)});
        cfg_write(csa_pkg::REG_APT_LOW, {31'($urandom), 32'($urandom)});
        cfg_write(csa_pkg::REG_SIG_MID, {31'($urandom), 32'($urandom_range(6144))});
        if (k % 4 == 2)
            cfg_write(csa_pkg::REG_SIG_SLOPE, {31'($urandom), 32'($urandom)});
        else
            cfg_write(csa_pkg::REG_SIG_SLOPE,
                      63'(int'($urandom_range(1 << 19)) - (1 << 18)));
        cfg_done();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // segment along x from -2 to 2, full aperture span, midpoint 2.0, slope 1.0
        cfg_write(csa_pkg::REG_SEG_START, pack_pt(-2048, 0, 0));
        cfg_write(csa_pkg::REG_SEG_END, pack_pt(2048, 0, 0));
        cfg_write(csa_pkg::REG_APT_HIGH, 63'hFFFF_FFFF);
        cfg_write(csa_pkg::REG_APT_LOW, 63'h0);
        cfg_write(csa_pkg::REG_SIG_MID, 63'd2048);
        cfg_write(csa_pkg::REG_SIG_SLOPE, 63'd65536);
        cfg_done();
        send_point(0, 0, 0);
        send_point(0, 1024, 0);
        send_point(-4096, 512, 0);
        send_point(4096, 512, 0);
        send_point(2048, 0, 0);
        send_point(-2048, 0, 0);
        send_point(1048575, 1048575, 1048575);
        send_point(-1048576, -1048576, -1048576);
        send_point(1048575, -1048576, 0);
        drain();

        // degenerate segment, zero slope, ignored writes
        cfg_write(csa_pkg::REG_SEG_START, pack_pt(1024, 1024, 1024));
        cfg_write(csa_pkg::REG_SEG_END, pack_pt(1024, 1024, 1024));
        cfg_write(csa_pkg::REG_APT_HIGH, {31'h7FFF_FFFF, 32'h1234_5678});
        cfg_write(csa_pkg::REG_APT_LOW, 63'h0100_0000);
        cfg_write(csa_pkg::REG_SIG_SLOPE, 63'd0);
        cfg_write(REG_UNUSED, 63'h7FFF_FFFF_FFFF_FFFF);
        cfg_write(REG_UNUSED_TOP, 63'h1);
        cfg_done();
        send_point(1024, 1024, 1024);
        send_point(-1048576, 1048575, 0);
        send_point(5000, -300, 77);
        drain();

        // saturating slopes and extreme midpoints over a full-range segment
        cfg_write(csa_pkg::REG_SEG_START, pack_pt(-1048576, -1048576, -1048576));
        cfg_write(csa_pkg::REG_SEG_END, pack_pt(1048575, 1048575, 1048575));
        cfg_write(csa_pkg::REG_SIG_SLOPE, 63'h7FFF_FFFF);
        cfg_done();
        send_point(0, 1048575, -1048576);
        send_point(1000, 1000, 1000);
        drain();
        cfg_write(csa_pkg::REG_SIG_SLOPE, 63'h8000_0000);
        cfg_done();
        send_point(0, 1048575, -1048576);
        send_point(1000, 1000, 1000);
        drain();
        cfg_write(csa_pkg::REG_SIG_MID, 63'h7FFF_FFFF);
        cfg_write(csa_pkg::REG_SIG_SLOPE, 63'd1);
        cfg_done();
        send_point(-1048576, 1048575, 0);
        drain();
        cfg_write(csa_pkg::REG_SIG_MID, 63'h8000_0000);
        cfg_done();
        send_point(-1048576, 1048575, 0);
        drain();

        for (int k = 0; k < 8; k++) begin
            random_config(k);
            idle_pct = (k % 4 == 1) ? 64 : (k % 4 == 3) ? 22 : 0;
            for (int j = 0; j < 229; j++) begin
                if (k == 2 && j == 114) begin
                    start <= 0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
                send_point(rand_coord(NEAR), rand_coord(NEAR), rand_coord(NEAR));
            end
            drain();
        end

        $display("Sent %0d points over 14 register settings: segment ends, interior, degenerate",
                 n_sent);
        $display("segments, saturating and zero slopes, idle gaps of 0, 22 and 64 percent.");
        if (fail_count == 0)
            $display("[capsule_sigmoid_aperture] OK");
        else
            $display("[capsule_sigmoid_aperture] ERROR");
        $finish;
    end

    initial begin
        #3000000;
        $display("[capsule_sigmoid_aperture] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/csa_pkg.sv
sv/csa_div_pipe.sv
sv/csa_isqrt_pipe.sv
sv/capsule_sigmoid_aperture.sv
tb/csa_checker.sv
tb/tb_top.sv
